FILE: rtl/clpp_pkg.sv
// Shared types and constants for the coefficient length prefix packer.
// No dependencies.
package clpp_pkg;

	localparam int LEN_BITS  = 5;
	localparam int MAX_LEN   = 16;
	localparam int BYTE_BITS = 8;
	localparam int PAY_BITS  = LEN_BITS + 1 + MAX_LEN;
	localparam int ACC_BITS  = 32;
	localparam int CNT_BITS  = 5;
	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR     = $clog2(Q_DEPTH);

	// one classified coefficient: code left-aligned in payload
	typedef struct packed {
		logic [PAY_BITS-1:0] payload;
		logic [CNT_BITS-1:0] nbits;
		logic                last;
	} clpp_entry_t;

endpackage

FILE: rtl/clpp_front.sv
// Front end: input register, magnitude and length classification.
// Uses clpp_pkg.
module clpp_front import clpp_pkg::*; #(
	parameter int COEF_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        coef_valid,
	output logic        coef_stall,
	input  logic [31:0] coefficient,
	input  logic        block_end,
	output logic        push,
	input  logic        q_full,
	output clpp_entry_t push_entry
);

	logic                  valid_s1;
	logic [COEF_WIDTH-1:0] coef_s1;
	logic                  last_s1;
	logic                  neg;
	logic [COEF_WIDTH-1:0] mag;
	logic                  mag_hi;
	logic [LEN_BITS-1:0]   len;
	logic [MAX_LEN:0]      mask;
	logic [MAX_LEN-1:0]    mag_m;
	logic [PAY_BITS-1:0]   raw;
	logic [LEN_BITS-1:0]   shamt;
	logic                  take;

	assign push       = valid_s1 && !q_full;
	assign coef_stall = valid_s1 && q_full;
	assign take       = coef_valid && !coef_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			coef_s1 <= coefficient[COEF_WIDTH-1:0];
			last_s1 <= block_end;
		end
	end

	assign neg    = coef_s1[COEF_WIDTH-1];
	assign mag    = neg ? (~coef_s1 + {{(COEF_WIDTH-1){1'b0}}, 1'b1}) : coef_s1;
	assign mag_hi = |mag[COEF_WIDTH-1:MAX_LEN-1];

	always_comb begin
		len = LEN_BITS'(1);
		for (int i = 0; i < MAX_LEN - 1; i++) begin
			if (mag[i]) begin
				len = LEN_BITS'(i + 2);
			end
		end
		if (mag_hi) begin
			len = LEN_BITS'(MAX_LEN);
		end
	end

	assign mask  = ~({(MAX_LEN+1){1'b1}} << len);
	assign mag_m = mag[MAX_LEN-1:0] & mask[MAX_LEN-1:0];
	assign shamt = LEN_BITS'(MAX_LEN) - len;
	assign raw   = {len, neg, MAX_LEN'(mag_m << shamt)};

	assign push_entry.payload = raw;
	assign push_entry.nbits   = CNT_BITS'(LEN_BITS + 1) + CNT_BITS'(len);
	assign push_entry.last    = last_s1;

endmodule

FILE: rtl/clpp_queue.sv
// Small FIFO of classified coefficients between front and back.
// Uses clpp_pkg.
module clpp_queue import clpp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  clpp_entry_t push_entry,
	output logic        full,
	input  logic        pop,
	output logic        empty,
	output clpp_entry_t pop_entry
);

	clpp_entry_t          mem [Q_DEPTH];
	logic [Q_PTR-1:0]     wr_q;
	logic [Q_PTR-1:0]     rd_q;
	logic [Q_PTR:0]       count_q;

	assign full      = (count_q == (Q_PTR+1)'(Q_DEPTH));
	assign empty     = (count_q == '0);
	assign pop_entry = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("queue pop while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (Q_PTR+1)'(Q_DEPTH)) else $error("queue count out of range");
`endif

endmodule

FILE: rtl/clpp_back.sv
// Back end: bit accumulator, byte extraction, block flush and output register.
// Uses clpp_pkg.
module clpp_back import clpp_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  clpp_entry_t    pop_entry,
	output logic           pop,
	output logic           byte_valid,
	input  logic           byte_stall,
	output logic [7:0]     packed_byte,
	output logic           block_done,
	output logic           run_last
);

	logic [ACC_BITS-1:0] sh_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                last_q;
	logic                out_valid_q;
	logic [7:0]          byte_q;
	logic                done_q;
	logic                rlast_q;

	logic                pending;
	logic                fire;
	logic [CNT_BITS-1:0] n_cnt;
	logic [ACC_BITS-1:0] n_sh;
	logic                n_pending;
	logic [CNT_BITS-1:0] base_cnt;
	logic [ACC_BITS-1:0] base_sh;
	logic [ACC_BITS-1:0] ins;

	assign pending   = (cnt_q >= CNT_BITS'(BYTE_BITS)) || (last_q && cnt_q != '0);
	assign fire      = pending && (!out_valid_q || !byte_stall);
	assign n_cnt     = (cnt_q >= CNT_BITS'(BYTE_BITS)) ? cnt_q - CNT_BITS'(BYTE_BITS) : '0;
	assign n_sh      = sh_q << BYTE_BITS;
	assign n_pending = (n_cnt >= CNT_BITS'(BYTE_BITS)) || (last_q && n_cnt != '0);
	assign pop       = !empty && (!pending || (fire && !n_pending));
	assign base_cnt  = fire ? n_cnt : cnt_q;
	assign base_sh   = fire ? n_sh : sh_q;
	assign ins       = {pop_entry.payload, {(ACC_BITS-PAY_BITS){1'b0}}} >> base_cnt[2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_q        <= '0;
			cnt_q       <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				sh_q   <= base_sh | ins;
				cnt_q  <= base_cnt + pop_entry.nbits;
				last_q <= pop_entry.last;
			end else if (fire) begin
				sh_q  <= n_sh;
				cnt_q <= n_cnt;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!byte_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			byte_q  <= sh_q[ACC_BITS-1 -: BYTE_BITS];
			rlast_q <= !n_pending;
			done_q  <= !n_pending && last_q;
		end
	end

	assign byte_valid  = out_valid_q;
	assign packed_byte = byte_q;
	assign block_done  = done_q;
	assign run_last    = rlast_q;

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_BITS'(29)) else $error("bit count out of range");
	a_tail_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(sh_q << cnt_q) == '0) else $error("stray bits beyond bit count");
	a_merge_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> base_cnt < CNT_BITS'(BYTE_BITS)) else $error("merge with full byte pending");
	a_flush_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && cnt_q < CNT_BITS'(BYTE_BITS)) |=> (block_done && run_last))
		else $error("padded byte without block end flags");
`endif

endmodule

FILE: rtl/coefficient_length_prefix_packer.sv
// Top level of the coefficient length prefix packer.
// Instantiates clpp_front, clpp_queue and clpp_back; uses clpp_pkg.
//
// Each coefficient is coded as a 5-bit length L, a sign bit and L magnitude
// bits (L = 1 for zero, floor(log2|v|)+2 otherwise, at most 16, upper
// magnitude bits dropped) and appended MSB-first to a byte stream; a block_end
// item pads and emits its partial byte. The input takes one transfer per cycle,
// unless coef_stall is raised while the queue is full, into a register and a
// four-entry queue; the back end then emits zero to four bytes per item, one at
// a time through the single-byte output register while byte_stall allows, and
// merges the next item once no further byte of the last one is pending.
module coefficient_length_prefix_packer import clpp_pkg::*; #(
	parameter int COEF_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        coef_valid,
	output logic        coef_stall,
	input  logic [31:0] coefficient,
	input  logic        block_end,
	output logic        byte_valid,
	input  logic        byte_stall,
	output logic [7:0]  packed_byte,
	output logic        block_done,
	output logic        run_last
);

	logic        push;
	logic        q_full;
	logic        q_empty;
	logic        pop;
	clpp_entry_t push_entry;
	clpp_entry_t pop_entry;

	clpp_front #(.COEF_WIDTH(COEF_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.coef_valid (coef_valid),
		.coef_stall (coef_stall),
		.coefficient(coefficient),
		.block_end  (block_end),
		.push       (push),
		.q_full     (q_full),
		.push_entry (push_entry)
	);

	clpp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.empty      (q_empty),
		.pop_entry  (pop_entry)
	);

	clpp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (q_empty),
		.pop_entry  (pop_entry),
		.pop        (pop),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.packed_byte(packed_byte),
		.block_done (block_done),
		.run_last   (run_last)
	);

endmodule
